// ===== rtl/core/lsac_pkg.sv =====
// Package for the LFU set-associative cache policy: sizes, types and helpers.
`default_nettype none
package lsac_pkg;

    localparam int SETS    = 16;
    localparam int WAYS    = 4;
    localparam int ENTRIES = SETS * WAYS;

    localparam int ADDR_W  = 32;
    localparam int COUNT_W = 16;
    localparam int MISS_W  = 32;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [MISS_W-1:0]  miss_t;
    typedef logic [WAY_W-1:0]   way_t;
    typedef logic [SET_W-1:0]   set_t;
    typedef logic [IDX_W-1:0]   idx_t;

    localparam count_t COUNT_MAX = '1;
    localparam miss_t  MISS_MAX  = '1;
    localparam way_t   LAST_WAY  = WAY_W'(WAYS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic   hit;
        way_t   hit_way;
        count_t hit_count;
        logic   full;
        way_t   victim;
    } scan_res_t;

    // sets must be a power of two: the modulo is a mask
    function automatic set_t set_of(addr_t a);
        return SET_W'(a % ADDR_W'(SETS));
    endfunction

    function automatic idx_t entry_idx(set_t s, way_t w);
        return IDX_W'(int'(s) * WAYS + int'(w));
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/lfu_set_assoc_cache_policy.sv =====
// Top level: LFU set-associative cache policy with a way-by-way lookup sequencer.
// One way of the set is read from the tag and count RAMs and compared per cycle,
// up to the first matching way or the last way; the update state then writes back,
// holding while a result waits on out_ready. Addresses are taken only when idle.
// Reset clears the valid bits, the miss counter and the sequencer; no clearing pass.
// Tag RAM contents are undefined after reset and are only read behind a valid bit.
`default_nettype none
module lfu_set_assoc_cache_policy (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire lsac_pkg::addr_t  addr,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  hit,
    output logic [1:0]            way_used,
    output logic                  evicted,
    output lsac_pkg::miss_t       miss_total
);
    import lsac_pkg::*;

    state_t              state_reg, state_next;
    addr_t               key_reg, key_next;
    way_t                way_reg, way_next;
    logic [ENTRIES-1:0]  valid_reg, valid_next;
    miss_t               miss_reg, miss_next;
    logic                out_valid_reg, out_valid_next;
    logic                hit_reg, hit_next;
    logic [1:0]          way_used_reg, way_used_next;
    logic                evicted_reg, evicted_next;

    idx_t      rd_idx;
    idx_t      cur_idx;
    idx_t      wr_idx;
    way_t      wr_way;
    logic      tag_we;
    logic      cnt_we;
    count_t    cnt_wdata;
    addr_t     rd_addr;
    count_t    rd_count;
    logic      start;
    logic      step;
    logic      match;
    scan_res_t res;

    lsac_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (ENTRIES)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (wr_idx),
        .wdata (key_reg),
        .raddr (rd_idx),
        .rdata (rd_addr)
    );

    lsac_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (ENTRIES)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (wr_idx),
        .wdata (cnt_wdata),
        .raddr (rd_idx),
        .rdata (rd_count)
    );

    assign cur_idx = entry_idx(set_of(key_reg), way_reg);

    lsac_way_unit u_way_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .step      (step),
        .way       (way_reg),
        .entry_vld (valid_reg[cur_idx]),
        .key       (key_reg),
        .rd_addr   (rd_addr),
        .rd_count  (rd_count),
        .match     (match),
        .res       (res)
    );

    assign wr_way = res.hit ? res.hit_way : res.victim;
    assign wr_idx = entry_idx(set_of(key_reg), wr_way);

    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        way_next       = way_reg;
        valid_next     = valid_reg;
        miss_next      = miss_reg;
        out_valid_next = out_valid_reg;
        hit_next       = hit_reg;
        way_used_next  = way_used_reg;
        evicted_next   = evicted_reg;
        in_ready       = 1'b0;
        start          = 1'b0;
        step           = 1'b0;
        tag_we         = 1'b0;
        cnt_we         = 1'b0;
        cnt_wdata      = '0;
        rd_idx         = entry_idx(set_of(key_reg), way_reg + 1'b1);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                rd_idx   = entry_idx(set_of(addr), '0);
                if (in_valid)
                begin
                    key_next   = addr;
                    way_next   = '0;
                    start      = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                step = 1'b1;
                if (match || (way_reg == LAST_WAY))
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    way_next = way_reg + 1'b1;
                end
            end
            ST_UPDATE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cnt_we = 1'b1;
                    if (res.hit)
                    begin
                        cnt_wdata = (res.hit_count == COUNT_MAX) ? res.hit_count
                                                                 : res.hit_count + 1'b1;
                    end
                    else
                    begin
                        tag_we             = 1'b1;
                        valid_next[wr_idx] = 1'b1;
                        if (miss_reg != MISS_MAX)
                        begin
                            miss_next = miss_reg + 1'b1;
                        end
                    end
                    out_valid_next = 1'b1;
                    hit_next       = res.hit;
                    way_used_next  = 2'(wr_way);
                    evicted_next   = !res.hit && res.full;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            way_reg       <= '0;
            valid_reg     <= '0;
            miss_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            way_reg       <= way_next;
            valid_reg     <= valid_next;
            miss_reg      <= miss_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        hit_reg      <= hit_next;
        way_used_reg <= way_used_next;
        evicted_reg  <= evicted_next;
    end

    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign way_used   = way_used_reg;
    assign evicted    = evicted_reg;
    assign miss_total = miss_reg;

endmodule
`default_nettype wire

// ===== rtl/core/lsac_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lsac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== rtl/core/lsac_way_unit.sv =====
// Shared per-way compare unit: tag match, first empty way and least-count tracking.
`default_nettype none
module lsac_way_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               step,
    input  wire lsac_pkg::way_t     way,
    input  wire logic               entry_vld,
    input  wire lsac_pkg::addr_t    key,
    input  wire lsac_pkg::addr_t    rd_addr,
    input  wire lsac_pkg::count_t   rd_count,
    output logic                    match,
    output lsac_pkg::scan_res_t     res
);
    import lsac_pkg::*;

    logic   hit_reg, hit_next;
    way_t   hit_way_reg, hit_way_next;
    count_t hit_count_reg, hit_count_next;
    logic   inv_found_reg, inv_found_next;
    way_t   inv_way_reg, inv_way_next;
    count_t min_count_reg, min_count_next;
    way_t   min_way_reg, min_way_next;

    assign match = entry_vld && (rd_addr == key);

    always_comb
    begin
        hit_next       = hit_reg;
        hit_way_next   = hit_way_reg;
        hit_count_next = hit_count_reg;
        inv_found_next = inv_found_reg;
        inv_way_next   = inv_way_reg;
        min_count_next = min_count_reg;
        min_way_next   = min_way_reg;
        if (start)
        begin
            hit_next       = 1'b0;
            inv_found_next = 1'b0;
            min_way_next   = '0;
        end
        else if (step)
        begin
            if (match)
            begin
                hit_next       = 1'b1;
                hit_way_next   = way;
                hit_count_next = rd_count;
            end
            if (!entry_vld && !inv_found_reg)
            begin
                inv_found_next = 1'b1;
                inv_way_next   = way;
            end
            if ((way == '0) || (rd_count < min_count_reg))
            begin
                min_count_next = rd_count;
                min_way_next   = way;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg       <= 1'b0;
            inv_found_reg <= 1'b0;
        end
        else
        begin
            hit_reg       <= hit_next;
            inv_found_reg <= inv_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_way_reg   <= hit_way_next;
        hit_count_reg <= hit_count_next;
        inv_way_reg   <= inv_way_next;
        min_count_reg <= min_count_next;
        min_way_reg   <= min_way_next;
    end

    assign res.hit       = hit_reg;
    assign res.hit_way   = hit_way_reg;
    assign res.hit_count = hit_count_reg;
    assign res.full      = !inv_found_reg;
    assign res.victim    = inv_found_reg ? inv_way_reg : min_way_reg;

endmodule
`default_nettype wire

// ===== rtl/core/lsac_checker.sv =====
// Port-level assertions for the LFU set-associative cache policy, bound to the top level.
`default_nettype none
module lsac_checker (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_ready,
    input  wire lsac_pkg::addr_t  addr,
    input  wire logic             out_valid,
    input  wire logic             out_ready,
    input  wire logic             hit,
    input  wire logic [1:0]       way_used,
    input  wire logic             evicted,
    input  wire lsac_pkg::miss_t  miss_total
);

    // a lookup runs through the scan and update states; no second beat right behind the first
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted in the cycle after an accepted beat");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_ready) |=> (in_valid && $stable(addr)))
        else $error("waiting input beat changed or dropped");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && evicted))
        else $error("result reports both hit and eviction");

    a_miss_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> (miss_total != '0))
        else $error("miss result with zero miss total");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(hit) && $stable(way_used) && $stable(evicted)
             && $stable(miss_total)))
        else $error("stalled result beat changed or dropped");

endmodule

bind lfu_set_assoc_cache_policy lsac_checker u_lsac_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .addr       (addr),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hit        (hit),
    .way_used   (way_used),
    .evicted    (evicted),
    .miss_total (miss_total)
);
`default_nettype wire
